// File: design/gmc_pkg.sv
// Shared types and constants for the graph m-coloring search core.
// Holds the opcode and sequencer state encodings and the memory control struct.
// No dependencies; every other design file imports this package.
`default_nettype none

package gmc_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int CFG_W            = 5;
	localparam int COLOR_W          = 5;
	localparam int COLOR_SPAN       = 2 ** COLOR_W;

	typedef enum logic [1:0] {
		OP_CLEAR    = 2'd0,
		OP_ADD_EDGE = 2'd1,
		OP_RUN      = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_START,
		ST_SCAN,
		ST_DECIDE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic clr;
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

`default_nettype wire

// File: design/gmc_vmem.sv
// Synchronous memory with one write and one registered read port per cycle.
// Per-entry valid bits let a single clr clear every entry; an invalid entry reads as zero.
// Depends on gmc_pkg for the control struct.
`default_nettype none

module gmc_vmem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire gmc_pkg::mem_ctl_t        ctl,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	output logic      [WIDTH-1:0]         rd_data
);
	import gmc_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_data_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// The valid bit is sampled with the read so that both come from the same edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// File: design/gmc_ctrl.sv
// Sequencer for the coloring search: edge loads and the backtracking loop.
// Drives the adjacency and color memories and builds a neighbor color mask per step.
// Depends on gmc_pkg.
`default_nettype none

module gmc_ctrl #(
	parameter int MAX_VERTICES = gmc_pkg::MAX_VERTICES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [1:0]                      opcode,
	input  wire logic [3:0]                      edge_first,
	input  wire logic [3:0]                      edge_second,
	input  wire logic [gmc_pkg::CFG_W-1:0]       vertex_count,
	input  wire logic [gmc_pkg::CFG_W-1:0]       color_limit,
	input  wire logic                            res_free,
	output logic                                 res_load,
	output logic                                 res_value,
	output gmc_pkg::mem_ctl_t                    adj_ctl,
	output logic [$clog2(MAX_VERTICES)-1:0]      adj_rd_addr,
	output logic [$clog2(MAX_VERTICES)-1:0]      adj_wr_addr,
	output logic [MAX_VERTICES-1:0]              adj_wr_data,
	input  wire logic [MAX_VERTICES-1:0]         adj_rd_data,
	output gmc_pkg::mem_ctl_t                    col_ctl,
	output logic [$clog2(MAX_VERTICES)-1:0]      col_rd_addr,
	output logic [$clog2(MAX_VERTICES)-1:0]      col_wr_addr,
	output logic [gmc_pkg::COLOR_W-1:0]          col_wr_data,
	input  wire logic [gmc_pkg::COLOR_W-1:0]     col_rd_data
);
	import gmc_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	state_t               state_q, state_d;
	opcode_t              op;
	logic                 accept;
	logic                 edge_ok;
	logic [CW-1:0]        n_sat;
	logic [CW-1:0]        d_q;
	logic [CW-1:0]        d_inc;
	logic [VW-1:0]        d_addr;
	logic [VW-1:0]        a_q, b_q;
	logic [VW-1:0]        k_q, k_s1;
	logic                 last_s1;
	logic [COLOR_SPAN-1:0] mask_q;
	logic [COLOR_W-1:0]   hi_q, cur_q;
	logic                 res_q;
	logic [COLOR_W:0]     hi_inc, cap;
	logic [COLOR_SPAN-1:0] cand;
	logic                 found;
	logic [COLOR_W-1:0]   c_sel;

	assign op     = opcode_t'(opcode);
	assign accept = in_valid && in_ready;
	assign edge_ok = (int'(edge_first) < MAX_VERTICES) && (int'(edge_second) < MAX_VERTICES);
	assign d_inc  = d_q + CW'(1);
	assign d_addr = d_q[VW-1:0];
	assign res_value = res_q;

	always_comb begin
		if (int'(vertex_count) > MAX_VERTICES) begin
			n_sat = CW'(MAX_VERTICES);
		end else begin
			n_sat = CW'(vertex_count);
		end
	end

	// Colors above one more than the highest color on earlier vertices are never tried.
	always_comb begin
		hi_inc = {1'b0, hi_q} + (COLOR_W+1)'(1);
		cap    = (hi_inc > {1'b0, color_limit}) ? {1'b0, color_limit} : hi_inc;
		for (int i = 0; i < COLOR_SPAN; i++) begin
			cand[i] = !mask_q[i] && ((COLOR_W+1)'(i) > {1'b0, cur_q}) &&
				((COLOR_W+1)'(i) <= cap);
		end
		found = |cand;
		c_sel = '0;
		for (int i = COLOR_SPAN - 1; i >= 0; i--) begin
			if (cand[i]) begin
				c_sel = COLOR_W'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op)
						OP_ADD_EDGE: begin
							if (edge_ok) begin
								state_d = ST_EDGE_A;
							end
						end
						OP_RUN: begin
							state_d = (n_sat == '0) ? ST_RESULT : ST_START;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_EDGE_A: state_d = ST_EDGE_B;
			ST_EDGE_B: state_d = ST_IDLE;
			ST_START:  state_d = ST_SCAN;
			ST_SCAN: begin
				if (last_s1) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (found) begin
					state_d = (d_inc == n_sat) ? ST_RESULT : ST_START;
				end else begin
					state_d = (d_q == '0) ? ST_RESULT : ST_START;
				end
			end
			ST_RESULT: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		res_load    = 1'b0;
		adj_ctl     = '0;
		col_ctl     = '0;
		adj_rd_addr = '0;
		adj_wr_addr = '0;
		adj_wr_data = '0;
		col_rd_addr = '0;
		col_wr_addr = '0;
		col_wr_data = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				adj_ctl.clr = in_valid && (op == OP_CLEAR);
				col_ctl.clr = in_valid && (op == OP_RUN);
				adj_ctl.rd_en = in_valid && (op == OP_ADD_EDGE) && edge_ok;
				adj_rd_addr = VW'(edge_first);
			end
			ST_EDGE_A: begin
				adj_ctl.wr_en = 1'b1;
				adj_wr_addr   = a_q;
				adj_wr_data   = adj_rd_data | (MAX_VERTICES'(1) << b_q);
				adj_ctl.rd_en = 1'b1;
				adj_rd_addr   = b_q;
			end
			ST_EDGE_B: begin
				adj_ctl.wr_en = 1'b1;
				adj_wr_addr   = b_q;
				adj_wr_data   = adj_rd_data | (MAX_VERTICES'(1) << a_q);
			end
			ST_START: begin
				adj_ctl.rd_en = 1'b1;
				adj_rd_addr   = d_addr;
				col_ctl.rd_en = 1'b1;
				col_rd_addr   = '0;
			end
			ST_SCAN: begin
				col_ctl.rd_en = !last_s1;
				col_rd_addr   = k_q;
			end
			ST_DECIDE: begin
				col_ctl.wr_en = 1'b1;
				col_wr_addr   = d_addr;
				col_wr_data   = found ? c_sel : '0;
			end
			ST_RESULT: begin
				res_load = res_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			d_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				d_q <= '0;
			end else if (state_q == ST_DECIDE) begin
				if (found) begin
					d_q <= d_inc;
				end else if (d_q != '0) begin
					d_q <= d_q - CW'(1);
				end
			end
		end
	end

	// Scan pipeline: a color read issued at k arrives in the next cycle, tagged by k_s1.
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q   <= VW'(edge_first);
			b_q   <= VW'(edge_second);
			res_q <= 1'b1;
		end
		case (state_q)
			ST_START: begin
				k_q     <= VW'(1);
				k_s1    <= '0;
				last_s1 <= (d_q == '0);
				mask_q  <= '0;
				hi_q    <= '0;
			end
			ST_SCAN: begin
				if (!last_s1) begin
					k_s1    <= k_q;
					last_s1 <= (k_q == d_addr);
					k_q     <= k_q + VW'(1);
					if (adj_rd_data[k_s1]) begin
						mask_q[col_rd_data] <= 1'b1;
					end
					if (col_rd_data > hi_q) begin
						hi_q <= col_rd_data;
					end
				end else begin
					cur_q <= col_rd_data;
				end
			end
			ST_DECIDE: begin
				if (!found && d_q == '0) begin
					res_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/graph_m_coloring_search_core.sv
// Graph m-coloring search core: opcodes clear the graph, add an undirected edge, or run
// a depth-first backtracking search that answers whether vertex_count vertices can be
// colored with at most color_limit colors. Add edge is a read-modify-write of both
// adjacency rows. A run returns one colorable result; each search step at depth d
// fetches the row, reads the color memory once per earlier vertex and once for the
// vertex itself through the single read port, then decides, and the step count grows
// with the amount of backtracking. Depends on gmc_pkg, gmc_vmem and gmc_ctrl.
`default_nettype none

module graph_m_coloring_search_core #(
	parameter int MAX_VERTICES = gmc_pkg::MAX_VERTICES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [1:0] opcode, [5:2] edge_first, [9:6] edge_second
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // [0] colorable
);
	import gmc_pkg::*;

	localparam int  VW               = $clog2(MAX_VERTICES);
	localparam logic REG_VERTEX_COUNT = 1'b0;
	localparam logic REG_COLOR_LIMIT  = 1'b1;

	logic [CFG_W-1:0]        vertex_count_q, color_limit_q;
	logic                    cfg_wr;
	logic                    m_tvalid_q, colorable_q;
	logic                    res_free, res_load, res_value;
	mem_ctl_t                adj_ctl, col_ctl;
	logic [VW-1:0]           adj_rd_addr, adj_wr_addr, col_rd_addr, col_wr_addr;
	logic [MAX_VERTICES-1:0] adj_wr_data, adj_rd_data;
	logic [COLOR_W-1:0]      col_wr_data, col_rd_data;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= CFG_W'(0);
			color_limit_q  <= CFG_W'(1);
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_VERTEX_COUNT: vertex_count_q <= pwdata[CFG_W-1:0];
				REG_COLOR_LIMIT:  color_limit_q  <= pwdata[CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_VERTEX_COUNT: prdata = {{(32-CFG_W){1'b0}}, vertex_count_q};
			REG_COLOR_LIMIT:  prdata = {{(32-CFG_W){1'b0}}, color_limit_q};
			default:          prdata = '0;
		endcase
	end

	// The result register lets new items enter while a result waits to be taken.
	assign res_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			colorable_q <= res_value;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, colorable_q};

	gmc_ctrl #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.opcode       (s_tdata[1:0]),
		.edge_first   (s_tdata[5:2]),
		.edge_second  (s_tdata[9:6]),
		.vertex_count (vertex_count_q),
		.color_limit  (color_limit_q),
		.res_free     (res_free),
		.res_load     (res_load),
		.res_value    (res_value),
		.adj_ctl      (adj_ctl),
		.adj_rd_addr  (adj_rd_addr),
		.adj_wr_addr  (adj_wr_addr),
		.adj_wr_data  (adj_wr_data),
		.adj_rd_data  (adj_rd_data),
		.col_ctl      (col_ctl),
		.col_rd_addr  (col_rd_addr),
		.col_wr_addr  (col_wr_addr),
		.col_wr_data  (col_wr_data),
		.col_rd_data  (col_rd_data)
	);

	gmc_vmem #(
		.DEPTH(MAX_VERTICES),
		.WIDTH(MAX_VERTICES)
	) u_adj_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (adj_ctl),
		.rd_addr (adj_rd_addr),
		.wr_addr (adj_wr_addr),
		.wr_data (adj_wr_data),
		.rd_data (adj_rd_data)
	);

	gmc_vmem #(
		.DEPTH(MAX_VERTICES),
		.WIDTH(COLOR_W)
	) u_color_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (col_ctl),
		.rd_addr (col_rd_addr),
		.wr_addr (col_wr_addr),
		.wr_data (col_wr_data),
		.rd_data (col_rd_data)
	);

	// A new result is loaded only when the previous one is gone or leaving.
	a_result_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over a pending result");

	// Memory writes belong to multi-cycle work, never to a cycle that takes input.
	a_no_write_while_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(adj_ctl.wr_en || col_ctl.wr_en))
		else $error("memory write while accepting input");

	// The coloring is wiped only when a run transaction is accepted.
	a_color_clear_on_run: assert property (@(posedge clk) disable iff (!arst_n)
		col_ctl.clr |-> (s_tvalid && s_tready))
		else $error("color memory cleared outside a run transaction");

	// After a result is loaded the block returns to idle and is ready for input again.
	a_result_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> s_tready)
		else $error("block did not return to idle after a result");

endmodule

`default_nettype wire

// File: verif/tb_graph_m_coloring_search_core.sv
// Self-checking testbench for graph_m_coloring_search_core: edge loads, clears and coloring
// runs on the stream port, vertex count and color limit set over APB, results checked in order.
// Depends on gmc_pkg and the graph_m_coloring_search_core RTL.
`default_nettype none

module tb_graph_m_coloring_search_core;
	import gmc_pkg::*;

	localparam int          MAX_V          = MAX_VERTICES_DEF;
	localparam logic [1:0]  OP_UNUSED      = 2'd3;
	localparam logic [2:0]  REG_VERTEX_CNT = 3'd0;
	localparam logic [2:0]  REG_COLOR_LIM  = 3'd4;
	localparam int          CYCLE_LIMIT    = 2_000_000;
	localparam int          SETTLE_CYCLES  = 10;
	localparam int          HOLD_LEN       = 400;
	localparam int unsigned RUN_COST_CAP   = 20_000;
	localparam int unsigned SEARCH_BUDGET  = 500_000;
	localparam int unsigned COST_CEILING   = 100_000;
	localparam int          RANDOM_ITEMS   = 1300;

	// Mirrors the adjacency store and both registers, and holds the verdicts of accepted runs.
	class coloring_scoreboard;
		logic [15:0]  adj_rows[MAX_V];
		logic [4:0]   vertex_count_reg;
		logic [4:0]   color_limit_reg;
		int unsigned  trial_colors[MAX_V];
		bit           expected_colorable[$];
		int unsigned  mismatches, runs, colorable_seen, edge_adds, clears, ignored;

		function new();
			foreach (adj_rows[i]) adj_rows[i] = '0;
			vertex_count_reg = 5'd0;
			color_limit_reg  = 5'd1;
		endfunction

		function void write_reg(logic [2:0] addr, logic [31:0] value);
			if (addr == REG_VERTEX_CNT) begin
				vertex_count_reg = value[4:0];
			end else if (addr == REG_COLOR_LIM) begin
				color_limit_reg = value[4:0];
			end
		endfunction

		function void add_expected(bit verdict);
			expected_colorable.insert(expected_colorable.size(), verdict);
		endfunction

		function bit color_fits(int unsigned node, int unsigned n, int unsigned c);
			for (int unsigned k = 0; k < n; k++)
				if (k != node && adj_rows[node][k] && trial_colors[k] == c)
					return 1'b0;
			return 1'b1;
		endfunction

		// Depth-first search over vertices in index order. A vertex never tries a color more
		// than one above the highest color used so far. The cost is an estimate of search
		// cycles that grows with each step and with its depth.
		function bit predict_colorable(output int unsigned cost);
			int unsigned n, m, d, hi, cap, c;
			n = (vertex_count_reg > MAX_V) ? MAX_V : vertex_count_reg;
			m = color_limit_reg;
			cost = 2;
			foreach (trial_colors[i]) trial_colors[i] = 0;
			if (n == 0)
				return 1'b1;
			d = 0;
			while (1) begin
				if (d == n)
					return 1'b1;
				if (cost > COST_CEILING)
					return 1'b0;
				cost += d + 3;
				hi = 0;
				for (int unsigned k = 0; k < d; k++)
					if (trial_colors[k] > hi)
						hi = trial_colors[k];
				cap = (hi + 1 > m) ? m : hi + 1;
				c = trial_colors[d] + 1;
				while (c <= cap && !color_fits(d, n, c))
					c++;
				if (c <= cap) begin
					trial_colors[d] = c;
					d++;
				end else begin
					trial_colors[d] = 0;
					if (d == 0)
						return 1'b0;
					d--;
				end
			end
		endfunction

		function void note_item(logic [1:0] op, logic [3:0] a, logic [3:0] b);
			int unsigned cost;
			case (op)
				OP_CLEAR: begin
					foreach (adj_rows[i]) adj_rows[i] = '0;
					clears++;
				end
				OP_ADD_EDGE: begin
					adj_rows[a][b] = 1'b1;
					adj_rows[b][a] = 1'b1;
					edge_adds++;
				end
				OP_RUN: begin
					add_expected(predict_colorable(cost));
					runs++;
				end
				default: ignored++;
			endcase
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		task check_result(bit got);
			bit want;
			if (expected_colorable.size() == 0) begin
				report_mismatch($sformatf("colorable=%0b arrived with no run pending", got));
			end else begin
				want = expected_colorable.pop_front();
				if (got != want)
					report_mismatch($sformatf("colorable expected %0b, got %0b", want, got));
				else if (got)
					colorable_seen++;
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [1:0] opcode, [5:2] edge_first, [9:6] edge_second
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [0] colorable

	coloring_scoreboard sb = new();
	int          cycle_count = 0;
	int          items_sent = 0;
	int          settings_applied = 0;
	int unsigned search_spent = 0;
	bit          steady = 1'b0;
	bit          sink_hold_request = 1'b0;

	graph_m_coloring_search_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Run stopped at the cycle limit with %0d results outstanding",
			sb.expected_colorable.size());
		$display("tb_graph_m_coloring_search_core failed");
		$finish;
	end

	// Result side: random back-pressure, plus one long hold-off when the stimulus asks.
	initial begin
		int hold_cycles;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold_request) begin
				m_tready = 1'b0;
				hold_cycles = 0;
				while (hold_cycles < HOLD_LEN) begin
					@(negedge clk);
					hold_cycles++;
				end
				sink_hold_request = 1'b0;
			end
			m_tready = steady || ($urandom_range(99) >= 22);
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[0]);

	task automatic apb_write(input logic [2:0] addr, input logic [4:0] value);
		logic [31:0] word;
		word = $urandom();
		word[4:0] = value;
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = word;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (pready)
			sb.write_reg(addr, word);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		@(negedge clk);
	endtask

	task automatic apb_check(input logic [2:0] addr, input logic [4:0] want);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = addr;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (prdata[4:0] !== want)
			sb.report_mismatch($sformatf("register at 0x%0h reads %0h, expected %0h",
				addr, prdata[4:0], want));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic [4:0] vertices, input logic [4:0] colors);
		apb_write(REG_VERTEX_CNT, vertices);
		apb_write(REG_COLOR_LIM, colors);
		apb_check(REG_VERTEX_CNT, vertices);
		apb_check(REG_COLOR_LIM, colors);
		settings_applied++;
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_item(input logic [1:0] op, input logic [3:0] a, input logic [3:0] b);
		while (!steady && $urandom_range(99) < 22) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {6'b0, b, a, op};
		do @(posedge clk); while (!s_tready);
		sb.note_item(op, a, b);
		if (op != OP_UNUSED)
			items_sent++;
		@(negedge clk);
	endtask

	// Clear and edge transactions give no result, so a further wait of SETTLE_CYCLES lets them finish.
	task automatic settle();
		s_tvalid = 1'b0;
		while (sb.expected_colorable.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_phase(input int n_items, input bit with_hold);
		int unsigned vc, cl, kind, lim, cost;
		logic [3:0]  a, b;
		bit          verdict;
		kind = $urandom_range(99);
		vc = (kind < 5) ? 0 : (kind < 70) ? $urandom_range(8, 1) :
			(kind < 85) ? $urandom_range(16, 9) : $urandom_range(31, 17);
		kind = $urandom_range(99);
		cl = (kind < 5) ? 0 : (kind < 65) ? $urandom_range(4, 1) :
			(kind < 85) ? $urandom_range(16, 5) : $urandom_range(31, 17);
		lim = (vc > MAX_V) ? MAX_V : vc;
		settle();
		configure(5'(vc), 5'(cl));
		if ($urandom_range(99) < 80)
			send_item(OP_CLEAR, 4'($urandom_range(15)), 4'($urandom_range(15)));
		if (with_hold)
			sink_hold_request = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			kind = $urandom_range(99);
			if (kind < 60) begin
				if (lim > 0 && $urandom_range(99) < 85) begin
					a = 4'($urandom_range(lim - 1));
					b = 4'($urandom_range(lim - 1));
				end else begin
					a = 4'($urandom_range(15));
					b = 4'($urandom_range(15));
				end
				send_item(OP_ADD_EDGE, a, b);
			end else if (kind < 88) begin
				// Runs that would search for too long are swapped for a clear.
				verdict = sb.predict_colorable(cost);
				if (cost > RUN_COST_CAP || search_spent + cost > SEARCH_BUDGET) begin
					send_item(OP_CLEAR, 4'($urandom_range(15)), 4'($urandom_range(15)));
				end else begin
					search_spent += cost;
					send_item(OP_RUN, 4'($urandom_range(15)), 4'($urandom_range(15)));
				end
			end else if (kind < 94) begin
				send_item(OP_CLEAR, 4'($urandom_range(15)), 4'($urandom_range(15)));
			end else begin
				send_item(OP_UNUSED, 4'($urandom_range(15)), 4'($urandom_range(15)));
			end
		end
	endtask

	initial begin
		int directed_items;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Values after reset: no vertices, so the graph is trivially colorable.
		send_item(OP_RUN, 4'd0, 4'd0);
		settle();
		configure(5'd4, 5'd0);
		send_item(OP_RUN, 4'hF, 4'hF);
		send_item(OP_ADD_EDGE, 4'd0, 4'd0);
		send_item(OP_ADD_EDGE, 4'hF, 4'hF);
		send_item(OP_ADD_EDGE, 4'd0, 4'hF);
		send_item(OP_UNUSED, 4'hF, 4'hF);
		send_item(OP_ADD_EDGE, 4'd0, 4'd1);
		send_item(OP_ADD_EDGE, 4'd1, 4'd2);
		send_item(OP_ADD_EDGE, 4'd2, 4'd0);
		settle();
		configure(5'd4, 5'd2);
		send_item(OP_RUN, 4'd0, 4'd0);
		settle();
		configure(5'd3, 5'd3);
		send_item(OP_RUN, 4'd0, 4'd0);
		send_item(OP_CLEAR, 4'hF, 4'hF);
		send_item(OP_RUN, 4'd0, 4'd0);
		// A vertex count above the store size saturates to the full graph.
		settle();
		configure(5'd31, 5'd1);
		send_item(OP_RUN, 4'd0, 4'd0);
		send_item(OP_ADD_EDGE, 4'd14, 4'd15);
		send_item(OP_RUN, 4'd0, 4'd0);
		settle();
		configure(5'd16, 5'd31);
		send_item(OP_ADD_EDGE, 4'd5, 4'd9);
		send_item(OP_RUN, 4'd0, 4'd0);
		settle();
		configure(5'd0, 5'd31);
		send_item(OP_RUN, 4'd0, 4'd0);
		directed_items = items_sent;

		random_phase(40, 1'b1);
		steady = 1'b1;
		random_phase(150, 1'b0);
		steady = 1'b0;
		while (items_sent < directed_items + RANDOM_ITEMS)
			random_phase($urandom_range(40, 8), 1'b0);

		settle();
		repeat (20) @(negedge clk);
		$display("Covered %0d runs (%0d colorable), %0d edge loads, %0d clears, %0d unused ops",
			sb.runs, sb.colorable_seen, sb.edge_adds, sb.clears, sb.ignored);
		$display("Register settings applied: %0d; mismatches: %0d",
			settings_applied, sb.mismatches);
		if (sb.mismatches == 0)
			$display("tb_graph_m_coloring_search_core passed");
		else
			$display("tb_graph_m_coloring_search_core failed");
		$finish;
	end

endmodule

`default_nettype wire
